/* hdl/ttc_pkg.sv */
// Shared types and constants for the triangle tile coverage block.
`timescale 1ns / 1ps
package ttc_pkg;

  localparam int TILE_IDX_W  = 9;
  localparam int COLOR_W     = 24;
  localparam int MASK_W      = 64;
  localparam int MASK_STRIDE = 8;
  localparam int NUM_EDGES   = 3;

  // Data that rides along with the triangle and comes out unchanged.
  typedef struct packed {
    logic [TILE_IDX_W-1:0] tile_col;
    logic [TILE_IDX_W-1:0] tile_row;
    logic [COLOR_W-1:0]    color;
  } ttc_side_t;

  // Per-stage load enables of the pipeline.
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
    logic s5;
  } ttc_pipe_en_t;

endpackage

/* hdl/ttc_setup.sv */
// Triangle setup: edge deltas, bounding box, tile-origin edge products and box masks.
`timescale 1ns / 1ps
module ttc_setup #(
  parameter int TileW     = 8,
  parameter int TileH     = 8,
  parameter int FracBits  = 4,
  parameter int PixelBits = 12
) (
  input  logic                                      clk_i,
  input  ttc_pkg::ttc_pipe_en_t                     en_i,
  input  logic        [PixelBits+FracBits-1:0]      vx_i [3],
  input  logic        [PixelBits+FracBits-1:0]      vy_i [3],
  input  ttc_pkg::ttc_side_t                        side_i,
  output logic signed [2*(PixelBits+FracBits)+1:0]  pa_o [3],
  output logic signed [2*(PixelBits+FracBits)+1:0]  pb_o [3],
  output logic signed [PixelBits+FracBits:0]        dx_o [3],
  output logic signed [PixelBits+FracBits:0]        dy_o [3],
  output logic        [TileW-1:0]                   col_ok_o,
  output logic        [TileH-1:0]                   row_ok_o,
  output ttc_pkg::ttc_side_t                        side_o
);
  import ttc_pkg::*;

  localparam int CW    = PixelBits + FracBits;
  localparam int EW    = 2 * CW + 2;
  localparam int PosXW = TILE_IDX_W + $clog2(TileW);
  localparam int PosYW = TILE_IDX_W + $clog2(TileH);
  localparam int BoxW  = PixelBits + 1;
  localparam int CmpXW = (PosXW > BoxW) ? PosXW : BoxW;
  localparam int CmpYW = (PosYW > BoxW) ? PosYW : BoxW;

  logic [CW-1:0]        min_x, max_x, min_y, max_y;
  logic [PosXW-1:0]     px0_d, px0_q;
  logic [PosYW-1:0]     py0_d, py0_q;
  logic [CW-1:0]        cx0, cy0;
  logic [PixelBits-1:0] left_d, left_q, top_d, top_q;
  logic [BoxW-1:0]      right_d, right_q, bot_d, bot_q;
  logic [TileW-1:0]     col_ok_d, col_ok_q;
  logic [TileH-1:0]     row_ok_d, row_ok_q;
  ttc_side_t            side1_q, side2_q;

  always_comb begin
    min_x = vx_i[0];
    max_x = vx_i[0];
    min_y = vy_i[0];
    max_y = vy_i[0];
    for (int i = 1; i < NUM_EDGES; i++) begin
      if (vx_i[i] < min_x) min_x = vx_i[i];
      if (vx_i[i] > max_x) max_x = vx_i[i];
      if (vy_i[i] < min_y) min_y = vy_i[i];
      if (vy_i[i] > max_y) max_y = vy_i[i];
    end
    left_d  = PixelBits'(min_x >> FracBits);
    top_d   = PixelBits'(min_y >> FracBits);
    right_d = BoxW'(({1'b0, max_x} + (CW+1)'((1 << FracBits) - 1)) >> FracBits);
    bot_d   = BoxW'(({1'b0, max_y} + (CW+1)'((1 << FracBits) - 1)) >> FracBits);
    px0_d   = PosXW'(side_i.tile_col) * PosXW'(TileW);
    py0_d   = PosYW'(side_i.tile_row) * PosYW'(TileH);
    // Center of the tile's first pixel; wraps only for tiles outside the box.
    cx0     = (CW'(px0_d) << FracBits) | (CW'(1) << (FracBits - 1));
    cy0     = (CW'(py0_d) << FracBits) | (CW'(1) << (FracBits - 1));
  end

  always_comb begin
    for (int c = 0; c < TileW; c++) begin
      col_ok_d[c] = (CmpXW'(px0_q) + CmpXW'(c) >= CmpXW'(left_q)) &&
                    (CmpXW'(px0_q) + CmpXW'(c) <  CmpXW'(right_q));
    end
    for (int r = 0; r < TileH; r++) begin
      row_ok_d[r] = (CmpYW'(py0_q) + CmpYW'(r) >= CmpYW'(top_q)) &&
                    (CmpYW'(py0_q) + CmpYW'(r) <  CmpYW'(bot_q));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s1) begin
      px0_q   <= px0_d;
      py0_q   <= py0_d;
      left_q  <= left_d;
      right_q <= right_d;
      top_q   <= top_d;
      bot_q   <= bot_d;
      side1_q <= side_i;
    end
    if (en_i.s2) begin
      col_ok_q <= col_ok_d;
      row_ok_q <= row_ok_d;
      side2_q  <= side1_q;
    end
  end

  // Edge k runs from vertex A to vertex B.
  for (genvar k = 0; k < NUM_EDGES; k++) begin : g_edge
    localparam int A = (k + 1) % NUM_EDGES;
    localparam int B = (k + 2) % NUM_EDGES;

    logic signed [CW:0]   dx_q, dy_q, ox_q, oy_q, dx2_q, dy2_q;
    logic signed [EW-1:0] pa_q, pb_q;

    always_ff @(posedge clk_i) begin
      if (en_i.s1) begin
        dx_q <= $signed({1'b0, vx_i[B]}) - $signed({1'b0, vx_i[A]});
        dy_q <= $signed({1'b0, vy_i[B]}) - $signed({1'b0, vy_i[A]});
        ox_q <= $signed({1'b0, cx0}) - $signed({1'b0, vx_i[A]});
        oy_q <= $signed({1'b0, cy0}) - $signed({1'b0, vy_i[A]});
      end
      if (en_i.s2) begin
        pa_q  <= EW'(ox_q) * EW'(dy_q);
        pb_q  <= EW'(oy_q) * EW'(dx_q);
        dx2_q <= dx_q;
        dy2_q <= dy_q;
      end
    end

    assign pa_o[k] = pa_q;
    assign pb_o[k] = pb_q;
    assign dx_o[k] = dx2_q;
    assign dy_o[k] = dy2_q;
  end

  assign col_ok_o = col_ok_q;
  assign row_ok_o = row_ok_q;
  assign side_o   = side2_q;

endmodule

/* hdl/ttc_row_lane.sv */
// One tile row: steps each edge function across the row and tests each pixel.
`timescale 1ns / 1ps
module ttc_row_lane #(
  parameter int TileW     = 8,
  parameter int FracBits  = 4,
  parameter int PixelBits = 12,
  parameter int RowIdx    = 0
) (
  input  logic                                      clk_i,
  input  ttc_pkg::ttc_pipe_en_t                     en_i,
  input  logic signed [2*(PixelBits+FracBits)+1:0]  pa_i [3],
  input  logic signed [2*(PixelBits+FracBits)+1:0]  pb_i [3],
  input  logic signed [PixelBits+FracBits:0]        dx_i [3],
  input  logic signed [PixelBits+FracBits:0]        dy_i [3],
  input  logic        [TileW-1:0]                   col_ok_i,
  input  logic                                      row_ok_i,
  output logic        [TileW-1:0]                   hit_o
);
  import ttc_pkg::*;

  localparam int CW = PixelBits + FracBits;
  localparam int EW = 2 * CW + 2;

  // Wraparound in these sums is harmless: the final weight of any pixel
  // inside the box fits in EW bits.
  logic signed [EW-1:0] er_q  [NUM_EDGES];
  logic signed [EW-1:0] dyf_q [NUM_EDGES];
  logic [TileW-1:0]     col_ok_q;
  logic                 row_ok_q;
  logic [TileW-1:0]     hit_d, hit_q;

  for (genvar k = 0; k < NUM_EDGES; k++) begin : g_edge
    always_ff @(posedge clk_i) begin
      if (en_i.s3) begin
        er_q[k]  <= pa_i[k] - pb_i[k] - EW'(RowIdx) * (EW'(dx_i[k]) <<< FracBits);
        dyf_q[k] <= EW'(dy_i[k]) <<< FracBits;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s3) begin
      col_ok_q <= col_ok_i;
      row_ok_q <= row_ok_i;
    end
    if (en_i.s4) begin
      hit_q <= hit_d;
    end
  end

  always_comb begin
    logic signed [EW-1:0] e;
    e     = '0;
    hit_d = '0;
    for (int c = 0; c < TileW; c++) begin
      hit_d[c] = col_ok_q[c] & row_ok_q;
      for (int k = 0; k < NUM_EDGES; k++) begin
        e        = er_q[k] + EW'(c) * dyf_q[k];
        hit_d[c] = hit_d[c] & ~e[EW-1];
      end
    end
  end

  assign hit_o = hit_q;

endmodule

/* hdl/ttc_merge.sv */
// Merge stage: gathers the row lanes into the coverage mask and holds the result.
`timescale 1ns / 1ps
module ttc_merge #(
  parameter int TileW = 8,
  parameter int TileH = 8
) (
  input  logic                             clk_i,
  input  ttc_pkg::ttc_pipe_en_t            en_i,
  input  ttc_pkg::ttc_side_t               side_i,
  input  logic [TileH-1:0][TileW-1:0]      hit_i,
  output ttc_pkg::ttc_side_t               side_o,
  output logic [ttc_pkg::MASK_W-1:0]       mask_o,
  output logic                             any_o
);
  import ttc_pkg::*;

  ttc_side_t         side3_q, side4_q, side5_q;
  logic [MASK_W-1:0] mask_d, mask_q;
  logic              any_q;

  always_comb begin
    mask_d = '0;
    for (int r = 0; r < TileH; r++) begin
      for (int c = 0; c < TileW; c++) begin
        mask_d[r * MASK_STRIDE + c] = hit_i[r][c];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s3) side3_q <= side_i;
    if (en_i.s4) side4_q <= side3_q;
    if (en_i.s5) begin
      side5_q <= side4_q;
      mask_q  <= mask_d;
      any_q   <= |mask_d;
    end
  end

  assign side_o = side5_q;
  assign mask_o = mask_q;
  assign any_o  = any_q;

endmodule

/* hdl/triangle_tile_coverage.sv */
// Channel   Direction  Handshake               Transaction
// input     in         in_valid_i/in_ready_o   triangle, color, tile position
// output    out        out_valid_o/out_ready_i tile position, color, coverage mask
//
// One transaction per cycle sustained while the output is not stalled.
// Setup, products, row bases, pixel tests and the merge register are the five stages.
// Each stage loads when empty or when the stage after it moves on, so bubbles close up
// and a stalled output still lets new transactions in until the pipeline is full.
// Reset clears only the stage valid bits.
`timescale 1ns / 1ps
module triangle_tile_coverage #(
  parameter int TILE_W     = 8,
  parameter int TILE_H     = 8,
  parameter int FRAC_BITS  = 4,
  parameter int PIXEL_BITS = 12
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [PIXEL_BITS+FRAC_BITS-1:0]      v1_x_i,
  input  logic [PIXEL_BITS+FRAC_BITS-1:0]      v1_y_i,
  input  logic [PIXEL_BITS+FRAC_BITS-1:0]      v2_x_i,
  input  logic [PIXEL_BITS+FRAC_BITS-1:0]      v2_y_i,
  input  logic [PIXEL_BITS+FRAC_BITS-1:0]      v3_x_i,
  input  logic [PIXEL_BITS+FRAC_BITS-1:0]      v3_y_i,
  input  logic [ttc_pkg::COLOR_W-1:0]          fill_color_i,
  input  logic [ttc_pkg::TILE_IDX_W-1:0]       tile_col_i,
  input  logic [ttc_pkg::TILE_IDX_W-1:0]       tile_row_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [ttc_pkg::TILE_IDX_W-1:0]       out_tile_col_o,
  output logic [ttc_pkg::TILE_IDX_W-1:0]       out_tile_row_o,
  output logic [ttc_pkg::COLOR_W-1:0]          out_color_o,
  output logic [ttc_pkg::MASK_W-1:0]           coverage_mask_o,
  output logic                                 any_covered_o
);
  import ttc_pkg::*;

  localparam int CW     = PIXEL_BITS + FRAC_BITS;
  localparam int EW     = 2 * CW + 2;
  localparam int STAGES = 5;

  logic [CW-1:0]        vx [3];
  logic [CW-1:0]        vy [3];
  ttc_side_t            side_in, side2, side_out;
  logic signed [EW-1:0] pa [3];
  logic signed [EW-1:0] pb [3];
  logic signed [CW:0]   dx [3];
  logic signed [CW:0]   dy [3];
  logic [TILE_W-1:0]    col_ok;
  logic [TILE_H-1:0]    row_ok;
  logic [TILE_H-1:0][TILE_W-1:0] hits;

  logic [STAGES-1:0]    valid_d, valid_q, rdy;
  ttc_pipe_en_t         en;

  assign vx[0] = v1_x_i;
  assign vx[1] = v2_x_i;
  assign vx[2] = v3_x_i;
  assign vy[0] = v1_y_i;
  assign vy[1] = v2_y_i;
  assign vy[2] = v3_y_i;

  assign side_in.tile_col = tile_col_i;
  assign side_in.tile_row = tile_row_i;
  assign side_in.color    = fill_color_i;

  always_comb begin
    rdy[STAGES-1] = !valid_q[STAGES-1] || out_ready_i;
    for (int s = STAGES - 2; s >= 0; s--) begin
      rdy[s] = !valid_q[s] || rdy[s+1];
    end
    valid_d[0] = rdy[0] ? in_valid_i : valid_q[0];
    for (int s = 1; s < STAGES; s++) begin
      valid_d[s] = rdy[s] ? valid_q[s-1] : valid_q[s];
    end
    en.s1 = rdy[0] & in_valid_i;
    en.s2 = rdy[1] & valid_q[0];
    en.s3 = rdy[2] & valid_q[1];
    en.s4 = rdy[3] & valid_q[2];
    en.s5 = rdy[4] & valid_q[3];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  ttc_setup #(
    .TileW     (TILE_W),
    .TileH     (TILE_H),
    .FracBits  (FRAC_BITS),
    .PixelBits (PIXEL_BITS)
  ) u_setup (
    .clk_i    (clk_i),
    .en_i     (en),
    .vx_i     (vx),
    .vy_i     (vy),
    .side_i   (side_in),
    .pa_o     (pa),
    .pb_o     (pb),
    .dx_o     (dx),
    .dy_o     (dy),
    .col_ok_o (col_ok),
    .row_ok_o (row_ok),
    .side_o   (side2)
  );

  for (genvar r = 0; r < TILE_H; r++) begin : g_lane
    ttc_row_lane #(
      .TileW     (TILE_W),
      .FracBits  (FRAC_BITS),
      .PixelBits (PIXEL_BITS),
      .RowIdx    (r)
    ) u_lane (
      .clk_i    (clk_i),
      .en_i     (en),
      .pa_i     (pa),
      .pb_i     (pb),
      .dx_i     (dx),
      .dy_i     (dy),
      .col_ok_i (col_ok),
      .row_ok_i (row_ok[r]),
      .hit_o    (hits[r])
    );
  end

  ttc_merge #(
    .TileW (TILE_W),
    .TileH (TILE_H)
  ) u_merge (
    .clk_i  (clk_i),
    .en_i   (en),
    .side_i (side2),
    .hit_i  (hits),
    .side_o (side_out),
    .mask_o (coverage_mask_o),
    .any_o  (any_covered_o)
  );

  assign in_ready_o     = rdy[0];
  assign out_valid_o    = valid_q[STAGES-1];
  assign out_tile_col_o = side_out.tile_col;
  assign out_tile_row_o = side_out.tile_row;
  assign out_color_o    = side_out.color;

endmodule

/* tb/testbench.sv */
// Testbench for triangle_tile_coverage: queued triangles, clocked driver/monitor, coverage checks.
`timescale 1ns / 1ps
module testbench;

  import ttc_pkg::*;

  localparam int COORD_W   = 16;
  localparam int TILE_W    = 8;
  localparam int TILE_H    = 8;
  localparam int FRAC_BITS = 4;
  localparam int N_RANDOM  = 1330;

  typedef struct {
    logic [COORD_W-1:0]    x1, y1, x2, y2, x3, y3;
    logic [COLOR_W-1:0]    color;
    logic [TILE_IDX_W-1:0] col, row;
    int                    gap;
    bit                    drain;
  } tri_t;

  typedef struct {
    logic [TILE_IDX_W-1:0] col, row;
    logic [COLOR_W-1:0]    color;
    logic [MASK_W-1:0]     mask;
    logic                  any;
  } cov_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_ready_o;
  logic [COORD_W-1:0]    v1_x_i = '0, v1_y_i = '0, v2_x_i = '0;
  logic [COORD_W-1:0]    v2_y_i = '0, v3_x_i = '0, v3_y_i = '0;
  logic [COLOR_W-1:0]    fill_color_i = '0;
  logic [TILE_IDX_W-1:0] tile_col_i = '0, tile_row_i = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic [TILE_IDX_W-1:0] out_tile_col_o, out_tile_row_o;
  logic [COLOR_W-1:0]    out_color_o;
  logic [MASK_W-1:0]     coverage_mask_o;
  logic                  any_covered_o;

  tri_t tri_q[$];
  cov_t cov_q[$];
  bit   in_fire = 1'b0;
  bit   out_fire = 1'b0;
  int   n_results = 0;
  int   n_err = 0;

  triangle_tile_coverage u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .v1_x_i         (v1_x_i),
    .v1_y_i         (v1_y_i),
    .v2_x_i         (v2_x_i),
    .v2_y_i         (v2_y_i),
    .v3_x_i         (v3_x_i),
    .v3_y_i         (v3_y_i),
    .fill_color_i   (fill_color_i),
    .tile_col_i     (tile_col_i),
    .tile_row_i     (tile_row_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_tile_col_o (out_tile_col_o),
    .out_tile_row_o (out_tile_row_o),
    .out_color_o    (out_color_o),
    .coverage_mask_o(coverage_mask_o),
    .any_covered_o  (any_covered_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Edge function of edge a->b at point c, units of 2^-(2*FRAC_BITS) pixel^2.
  function automatic longint edge_w(longint ax, longint ay, longint bx, longint by,
                                    longint cx, longint cy);
    return (cx - ax) * (by - ay) - (cy - ay) * (bx - ax);
  endfunction

  function automatic cov_t tile_coverage(tri_t t);
    cov_t   res;
    longint x1, y1, x2, y2, x3, y3;
    longint left, top, right, bottom, px, py, cx, cy;
    longint mn, mx;
    res.col   = t.col;
    res.row   = t.row;
    res.color = t.color;
    res.mask  = '0;
    x1 = longint'(t.x1); y1 = longint'(t.y1); x2 = longint'(t.x2);
    y2 = longint'(t.y2); x3 = longint'(t.x3); y3 = longint'(t.y3);
    mn = (x1 < x2) ? x1 : x2;
    mn = (mn < x3) ? mn : x3;
    mx = (x1 > x2) ? x1 : x2;
    mx = (mx > x3) ? mx : x3;
    left  = mn >>> FRAC_BITS;
    right = (mx + longint'((1 << FRAC_BITS) - 1)) >>> FRAC_BITS;
    mn = (y1 < y2) ? y1 : y2;
    mn = (mn < y3) ? mn : y3;
    mx = (y1 > y2) ? y1 : y2;
    mx = (mx > y3) ? mx : y3;
    top    = mn >>> FRAC_BITS;
    bottom = (mx + longint'((1 << FRAC_BITS) - 1)) >>> FRAC_BITS;
    for (int r = 0; r < TILE_H; r++) begin
      py = longint'(t.row) * longint'(TILE_H) + longint'(r);
      if (py >= top && py < bottom) begin
        for (int c = 0; c < TILE_W; c++) begin
          px = longint'(t.col) * longint'(TILE_W) + longint'(c);
          if (px >= left && px < right) begin
            cx = (px << FRAC_BITS) + longint'(1 << (FRAC_BITS - 1));
            cy = (py << FRAC_BITS) + longint'(1 << (FRAC_BITS - 1));
            if (edge_w(x2, y2, x3, y3, cx, cy) >= 0 &&
                edge_w(x3, y3, x1, y1, cx, cy) >= 0 &&
                edge_w(x1, y1, x2, y2, cx, cy) >= 0)
              res.mask[r*MASK_STRIDE+c] = 1'b1;
          end
        end
      end
    end
    res.any = (res.mask != '0);
    return res;
  endfunction

  function automatic logic [COORD_W-1:0] clamp_coord(int v);
    if (v < 0) return '0;
    if (v > 65535) return '1;
    return v[COORD_W-1:0];
  endfunction

  task automatic add_tri(int x1, int y1, int x2, int y2, int x3, int y3,
                         logic [COLOR_W-1:0] color, int col, int row, int gap);
    tri_t t;
    t.x1 = clamp_coord(x1); t.y1 = clamp_coord(y1);
    t.x2 = clamp_coord(x2); t.y2 = clamp_coord(y2);
    t.x3 = clamp_coord(x3); t.y3 = clamp_coord(y3);
    t.color = color;
    t.col   = col[TILE_IDX_W-1:0];
    t.row   = row[TILE_IDX_W-1:0];
    t.gap   = gap;
    t.drain = 1'b0;
    tri_q.push_back(t);
  endtask

  task automatic report(string field, logic [MASK_W-1:0] exp_v, logic [MASK_W-1:0] act_v);
    $display("%0t mismatch on %s: expected %h actual %h", $realtime, field, exp_v, act_v);
    n_err++;
  endtask

  // Monitor: records accepted inputs as expectations, checks accepted outputs.
  always @(posedge clk_i) begin
    tri_t t;
    cov_t exp_c;
    if (rst_ni) begin
      in_fire  <= in_valid_i && in_ready_o;
      out_fire <= out_valid_o && out_ready_i;
      if (in_valid_i && in_ready_o) begin
        t.x1 = v1_x_i; t.y1 = v1_y_i; t.x2 = v2_x_i; t.y2 = v2_y_i;
        t.x3 = v3_x_i; t.y3 = v3_y_i;
        t.color = fill_color_i; t.col = tile_col_i; t.row = tile_row_i;
        t.gap = 0; t.drain = 1'b0;
        cov_q.push_back(tile_coverage(t));
      end
      if (out_valid_o && out_ready_i) begin
        n_results <= n_results + 1;
        if (cov_q.size() == 0) begin
          $display("%0t unexpected transaction: expected none actual mask %h",
                   $realtime, coverage_mask_o);
          n_err++;
        end else begin
          exp_c = cov_q.pop_front();
          if (out_tile_col_o !== exp_c.col)
            report("out_tile_col", MASK_W'(exp_c.col), MASK_W'(out_tile_col_o));
          if (out_tile_row_o !== exp_c.row)
            report("out_tile_row", MASK_W'(exp_c.row), MASK_W'(out_tile_row_o));
          if (out_color_o !== exp_c.color)
            report("out_color", MASK_W'(exp_c.color), MASK_W'(out_color_o));
          if (coverage_mask_o !== exp_c.mask)
            report("coverage_mask", exp_c.mask, coverage_mask_o);
          if (any_covered_o !== exp_c.any)
            report("any_covered", MASK_W'(exp_c.any), MASK_W'(any_covered_o));
        end
      end
    end
  end

  // Driver: front of tri_q is the transaction being offered.
  int gap_cnt = 0;
  bit gap_loaded = 1'b0;
  always @(negedge clk_i) begin
    logic nxt_valid;
    if (rst_ni) begin
      if (in_fire) begin
        void'(tri_q.pop_front());
        gap_loaded = 1'b0;
      end
      if (!(in_valid_i && !in_fire)) begin
        nxt_valid = 1'b0;
        if (tri_q.size() > 0) begin
          if (!gap_loaded) begin
            gap_cnt    = tri_q[0].gap;
            gap_loaded = 1'b1;
          end
          if (tri_q[0].drain && cov_q.size() != 0) begin
            // wait for the pipeline to empty
          end else if (gap_cnt > 0) begin
            gap_cnt--;
          end else begin
            nxt_valid = 1'b1;
            v1_x_i       <= tri_q[0].x1;
            v1_y_i       <= tri_q[0].y1;
            v2_x_i       <= tri_q[0].x2;
            v2_y_i       <= tri_q[0].y2;
            v3_x_i       <= tri_q[0].x3;
            v3_y_i       <= tri_q[0].y3;
            fill_color_i <= tri_q[0].color;
            tile_col_i   <= tri_q[0].col;
            tile_row_i   <= tri_q[0].row;
          end
        end
        in_valid_i <= nxt_valid;
      end
    end
  end

  // Receiver: random wait per result except in periodic no-wait runs, one long hold-off to back up the pipeline.
  int rx_wait = 0;
  int hold_cnt = 0;
  bit held = 1'b0;
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!held && n_results >= 250) begin
        hold_cnt = 400;
        held     = 1'b1;
      end
      if (out_fire) begin
        if (n_results % 300 >= 240) rx_wait = 0;
        else rx_wait = $urandom_range(0, 16);
      end else if (rx_wait > 0) begin
        rx_wait--;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= (rx_wait == 0);
      end
    end
  end

  initial begin
    int col, row, bx, by, spread, kind, gap;
    int x[3], y[3];
    // Directed: extremes, both windings, centers on edges, degenerate, off-tile.
    add_tri(0, 0, 0, 0, 0, 0, 24'h000000, 0, 0, 0);
    add_tri(65535, 65535, 65535, 65535, 65535, 65535, 24'hFFFFFF, 511, 511, 3);
    add_tri(0, 0, 0, 4000, 4000, 0, 24'h123456, 0, 0, 0);
    add_tri(0, 0, 4000, 0, 0, 4000, 24'h654321, 0, 0, 16);
    add_tri(8, 8, 8, 120, 120, 8, 24'hFF0000, 0, 0, 0);
    add_tri(8, 8, 120, 8, 8, 120, 24'h00FF00, 0, 0, 2);
    add_tri(8, 8, 72, 72, 120, 120, 24'h0000FF, 0, 0, 0);
    add_tri(120, 120, 8, 8, 72, 72, 24'h0000FF, 0, 0, 0);
    add_tri(0, 32, 100, 32, 50, 32, 24'h808080, 0, 0, 5);
    add_tri(48, 0, 48, 100, 48, 60, 24'h7F7F7F, 0, 0, 0);
    add_tri(0, 0, 0, 4000, 4000, 0, 24'hABCDEF, 10, 0, 0);
    add_tri(0, 0, 0, 4000, 4000, 0, 24'hFEDCBA, 0, 10, 1);
    add_tri(64000, 64000, 64000, 65535, 65535, 64000, 24'h010203, 511, 511, 0);
    add_tri(64000, 64000, 65535, 64000, 64000, 65535, 24'h040506, 511, 511, 0);
    add_tri(0, 0, 0, 65535, 65535, 0, 24'hFFFFFF, 255, 100, 0);
    add_tri(0, 0, 65535, 0, 0, 65535, 24'h000000, 100, 255, 0);
    add_tri(0, 0, 0, 65535, 65535, 0, 24'h5A5A5A, 0, 511, 4);
    add_tri('hAAAA, 'h5555, 'h5555, 'hAAAA, 'hAAAA, 'hAAAA,
            24'hAAAAAA, 'h155, 'h0AA, 0);
    add_tri('h5555, 'hAAAA, 'hAAAA, 'h5555, 'h5555, 'h5555,
            24'h555555, 'h0AA, 'h155, 0);
    add_tri('hFFFF, 'h0000, 'h0000, 'hFFFF, 'hFFFF, 'hFFFF,
            24'hF0F0F0, 'h1FF, 'h1FF, 0);
    add_tri(16, 16, 16, 16, 112, 112, 24'h0F0F0F, 0, 0, 0);

    for (int i = 0; i < N_RANDOM; i++) begin
      gap  = (i % 300 < 60) ? 0 : $urandom_range(0, 16);
      kind = $urandom_range(0, 99);
      col  = $urandom_range(0, 511);
      row  = $urandom_range(0, 511);
      if (kind < 20) begin
        // noise: anywhere on the full coordinate range
        for (int k = 0; k < 3; k++) begin
          x[k] = $urandom_range(0, 65535);
          y[k] = $urandom_range(0, 65535);
        end
      end else begin
        bx = col * TILE_W * 16 + 64;
        by = row * TILE_H * 16 + 64;
        spread = $urandom_range(2, 24) * 16;
        for (int k = 0; k < 3; k++) begin
          x[k] = bx + $urandom_range(0, spread) - spread / 2;
          y[k] = by + $urandom_range(0, spread) - spread / 2;
          if (kind < 40) begin
            // vertices on pixel centers put pixel centers on edges
            x[k] = (x[k] & ~15) | 8;
            y[k] = (y[k] & ~15) | 8;
          end
        end
        if (kind >= 90) begin
          // collinear: third vertex at the midpoint of the first two
          x[0] = x[0] & ~1; x[1] = x[1] & ~1;
          y[0] = y[0] & ~1; y[1] = y[1] & ~1;
          x[2] = (x[0] + x[1]) / 2;
          y[2] = (y[0] + y[1]) / 2;
        end
      end
      add_tri(x[0], y[0], x[1], y[1], x[2], y[2], COLOR_W'($urandom_range(0, 24'hFFFFFF)),
              col, row, gap);
    end
    // Two points where the sender waits for the pipeline to empty.
    tri_q[21].drain = 1'b1;
    tri_q[700].drain = 1'b1;

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (tri_q.size() != 0 || in_valid_i || cov_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (n_err == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("FAIL");
    $finish;
  end

endmodule
